/* rtl/sha256bsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256bsh_pkg
// Types, round constants, initial hash values and round functions for the
// SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha256bsh_pkg;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_FINISH = 1'b1
    } t_kind;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic [7:0]  PAD_MARK      = 8'h80;
    localparam logic [5:0]  LEN_POS       = 6'd56;
    localparam logic [5:0]  FILL_LAST     = 6'd63;
    localparam logic [5:0]  ROUND_LAST    = 6'd63;
    localparam logic [2:0]  WORD_LAST     = 3'd7;
    localparam logic [63:0] BLOCK_BITS    = 64'd512;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] hash_iv(input logic [2:0] idx);
        case (idx)
            3'd0: hash_iv = 32'h6a09e667;
            3'd1: hash_iv = 32'hbb67ae85;
            3'd2: hash_iv = 32'h3c6ef372;
            3'd3: hash_iv = 32'ha54ff53a;
            3'd4: hash_iv = 32'h510e527f;
            3'd5: hash_iv = 32'h9b05688c;
            3'd6: hash_iv = 32'h1f83d9ab;
            3'd7: hash_iv = 32'h5be0cd19;
            default: hash_iv = 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

/* rtl/sha256_byte_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// Message bytes are taken one per cycle into a 512-bit shift window; every
// 64th byte starts a compression that runs one SHA-256 round per cycle on a
// single round unit (64 rounds, then a fold into the hash state), with
// the message schedule computed in place inside the same window. A finish
// transaction shifts in the padding and the big-endian bit length one byte a
// cycle (64 minus the fill bytes, plus 64 more when the fill is 56 or above),
// runs one or two compressions, then presents the eight digest words
// H0 first, one per cycle while the output side is ready. The input is not
// ready while a compression, padding or digest output is in progress.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream with a shared one-round-per-cycle compressor.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  sha256bsh_pkg::t_in_item i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output sha256bsh_pkg::t_out_item o_out
);
    import sha256bsh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    t_state        r_state;
    logic [31:0]   r_hash [8];
    logic [31:0]   r_v    [8];
    logic [31:0]   r_w    [16];
    logic [5:0]    r_fill;
    logic [5:0]    r_round;
    logic [63:0]   r_bits;
    logic [63:0]   r_len;
    logic          r_pad;
    logic          r_first;
    logic          r_len_ok;
    logic [2:0]    r_oidx;

    logic [7:0]    n_byte;
    logic [31:0]   n_w_byte  [16];
    logic [31:0]   n_w_round [16];
    logic [31:0]   n_v       [8];
    logic [31:0]   n_sched;
    logic [31:0]   n_t1;
    logic [31:0]   n_t2;

    // byte entering the window
    always_comb begin
        if (r_state == ST_PAD) begin
            if (r_first) begin
                n_byte = PAD_MARK;
            end else if (r_len_ok && (r_fill >= LEN_POS)) begin
                n_byte = r_len[63:56];
            end else begin
                n_byte = 8'h00;
            end
        end else begin
            n_byte = i_in.data_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < 15; i++) begin
            n_w_byte[i] = {r_w[i][23:0], r_w[i+1][31:24]};
        end
        n_w_byte[15] = {r_w[15][23:0], n_byte};
    end

    // round unit and schedule
    always_comb begin
        n_sched = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        for (int i = 0; i < 15; i++) begin
            n_w_round[i] = r_w[i+1];
        end
        n_w_round[15] = n_sched;

        n_t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + round_k(r_round) + r_w[0];
        n_t2 = big_sigma0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + n_t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = n_t1 + n_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_round  <= '0;
            r_bits   <= '0;
            r_pad    <= 1'b0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
            r_oidx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= hash_iv(3'(i));
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in.kind == KIND_FINISH) begin
                            r_len    <= r_bits + {55'd0, r_fill, 3'd0};
                            r_pad    <= 1'b1;
                            r_first  <= 1'b1;
                            r_len_ok <= 1'b0;
                            r_state  <= ST_PAD;
                        end else begin
                            r_w    <= n_w_byte;
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == FILL_LAST) begin
                                r_bits  <= r_bits + BLOCK_BITS;
                                r_pad   <= 1'b0;
                                r_v     <= r_hash;
                                r_round <= '0;
                                r_state <= ST_COMP;
                            end
                        end
                    end
                end
                ST_PAD: begin
                    r_w     <= n_w_byte;
                    r_fill  <= r_fill + 6'd1;
                    r_first <= 1'b0;
                    if (r_first && (r_fill < LEN_POS)) begin
                        r_len_ok <= 1'b1;
                    end
                    if (!r_first && r_len_ok && (r_fill >= LEN_POS)) begin
                        r_len <= {r_len[55:0], 8'h00};
                    end
                    if (r_fill == FILL_LAST) begin
                        r_v     <= r_hash;
                        r_round <= '0;
                        r_state <= ST_COMP;
                    end
                end
                ST_COMP: begin
                    r_v     <= n_v;
                    r_w     <= n_w_round;
                    r_round <= r_round + 6'd1;
                    if (r_round == ROUND_LAST) begin
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    if (!r_pad) begin
                        r_state <= ST_IDLE;
                    end else if (r_len_ok) begin
                        r_oidx  <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        // padding spilled into a second block
                        r_len_ok <= 1'b1;
                        r_state  <= ST_PAD;
                    end
                end
                ST_OUT: begin
                    if (i_out_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == WORD_LAST) begin
                            for (int i = 0; i < 8; i++) begin
                                r_hash[i] <= hash_iv(3'(i));
                            end
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_pad   <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            for (int i = 0; i < 7; i++) begin
                                r_hash[i] <= r_hash[i+1];
                            end
                            r_hash[7] <= r_hash[0];
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = (r_state == ST_OUT);
    assign o_out.digest_word = r_hash[0];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == WORD_LAST);

    // rounds only run on a complete block
    a_comp_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP) |-> (r_fill == 6'd0))
        else $error("compression running on a partial block");

    // digest words come out in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last_word)
        |=> (o_out_valid && (o_out.word_index == $past(o_out.word_index) + 3'd1)))
        else $error("digest word index out of sequence");

    // hasher returns to its initial state after the last word
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.last_word)
        |=> (o_in_ready && (r_hash[0] == hash_iv(3'd0)) && (r_bits == 64'd0)))
        else $error("hash state not restored after digest");

    // input and output sides are never open together (checked after each fold)
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD) |=> !(o_in_ready && o_out_valid))
        else $error("input ready while digest pending");

endmodule

/* tb/sv/sha256_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 byte stream hasher. Every accepted
// input transaction goes into a local SHA-256 model, and a finish queues the
// eight expected digest words. Every accepted output transaction is compared
// field by field with the oldest expected word. The failure count and the
// number of words still due go to the testbench top.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  sha256bsh_pkg::t_in_item  i_in,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  sha256bsh_pkg::t_out_item i_out,
    output int                       o_fail_count,
    output int                       o_words_due
);
    import sha256bsh_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LENGTH_OFFSET = 56;

    localparam logic [255:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [2047:0] K_WORDS = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] chain_words [8];
    logic [7:0]  block_bytes [64];
    logic [5:0]  block_count;
    logic [63:0] hashed_bits;
    t_out_item   digest_words_due [$];
    int          fail_count = 0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) begin
            chain_words[i] = IV_WORDS[(7 - i) * 32 +: 32];
        end
        block_count = '0;
        hashed_bits = '0;
    endfunction

    function automatic void compress_buffer();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
                    block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
            s1 = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
            w[i] = s1 + w[i - 7] + s0 + w[i - 16];
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = chain_words[i];
        end
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6]))
                 + K_WORDS[(63 - i) * 32 +: 32] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain_words[i] = chain_words[i] + v[i];
        end
    endfunction

    function automatic void absorb_transaction(input t_in_item item);
        logic [63:0] total;
        int          pos;
        t_out_item   word;
        if (item.kind == KIND_BYTE) begin
            block_bytes[block_count] = item.data_byte;
            block_count = block_count + 6'd1;
            if (block_count == 6'd0) begin
                compress_buffer();
                hashed_bits = hashed_bits + 64'd512;
            end
        end else begin
            total = hashed_bits + {55'd0, block_count, 3'd0};
            pos = block_count;
            block_bytes[pos] = PAD_BYTE;
            pos++;
            if (pos > LENGTH_OFFSET) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                compress_buffer();
                pos = 0;
            end
            while (pos < LENGTH_OFFSET) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++) begin
                block_bytes[63 - i] = total[8 * i +: 8];
            end
            compress_buffer();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = chain_words[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                digest_words_due.push_back(word);
            end
            restart_message();
        end
    endfunction

    function automatic void check_transaction(input t_out_item got);
        t_out_item want;
        if (digest_words_due.size() == 0) begin
            if (fail_count < MAX_REPORTS) begin
                $display("unexpected digest word %h index %0d last %0b",
                         got.digest_word, got.word_index, got.last_word);
            end
            fail_count++;
        end else begin
            want = digest_words_due.pop_front();
            if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
                got.last_word !== want.last_word) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                             want.digest_word, want.word_index, want.last_word,
                             got.digest_word, got.word_index, got.last_word);
                end
                fail_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            digest_words_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                absorb_transaction(i_in);
            end
            if (i_out_valid && i_out_ready) begin
                check_transaction(i_out);
            end
        end
        o_words_due = digest_words_due.size();
    end

    initial begin
        o_words_due = 0;
    end

    assign o_fail_count = fail_count;

endmodule

/* tb/sv/sha256_byte_stream_hasher_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit_tb
// Feeds messages of directed and random lengths, with emphasis on the padding
// boundaries, byte by byte into the hasher in random bursts, and stalls the
// digest side on changing patterns. A checker beside the block predicts every
// digest word; the top gives the verdict or stops on a stall watchdog.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit_tb;
    import sha256bsh_pkg::*;

    localparam int RANDOM_ITEMS = 380;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 200;

    localparam int READY_ALWAYS = 0;
    localparam int READY_RANDOM = 1;
    localparam int READY_SPARSE = 2;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    int fail_count;
    int words_due;
    int burst_left  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int ready_mode  = READY_ALWAYS;
    int mode_left   = 0;
    int sparse_cnt  = 0;

    always #5 i_clk = ~i_clk;

    sha256_byte_stream_hasher_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    sha256_digest_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .o_fail_count(fail_count),
        .o_words_due (words_due)
    );

    // digest side stall patterns
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(READY_ALWAYS, READY_SPARSE);
            mode_left  <= $urandom_range(20, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        sparse_cnt <= sparse_cnt + 1;
        case (ready_mode)
            READY_ALWAYS: begin
                i_out_ready <= 1'b1;
            end
            READY_RANDOM: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_out_ready <= (sparse_cnt % 5 == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_in.kind      <= kind;
        i_in.data_byte <= data;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 15))
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_item(KIND_BYTE, b);
        end
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int start_count;
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty messages (finish byte ignored), then two short messages
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_BYTE, 8'h61);
        send_item(KIND_BYTE, 8'h62);
        send_item(KIND_BYTE, 8'h63);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_BYTE, 8'h7f);
        send_item(KIND_FINISH, 8'h5a);

        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 12);
                8, 9: len = $urandom_range(0, 200);
                default: begin
                    case ($urandom_range(0, 11))
                        0: len = 0;
                        1: len = 1;
                        2: len = 55;
                        3: len = 56;
                        4: len = 57;
                        5: len = 63;
                        6: len = 64;
                        7: len = 65;
                        8: len = 119;
                        9: len = 120;
                        10: len = 127;
                        default: len = 128;
                    endcase
                end
            endcase
            // keep the total near the item budget
            if (len > RANDOM_ITEMS - (items_sent - start_count) - 1) begin
                len = RANDOM_ITEMS - (items_sent - start_count) - 1;
            end
            send_message(len);
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && words_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sha256bsh_pkg.sv
rtl/sha256_byte_stream_hasher_unit.sv
tb/sv/sha256_digest_checker.sv
tb/sv/sha256_byte_stream_hasher_unit_tb.sv
